FILE: sv/srtl_pkg.sv
`timescale 1ns / 1ps

package srtl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADRANGE = 2'd3;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] limit;
    logic [15:0] sym;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic        is_entry;
    logic [15:0] match_id;
  } result_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

FILE: sv/sorted_range_table_lookup_core.sv
`timescale 1ns / 1ps
// A lookup is a binary search: each probe reads one table entry (S_LK_RD) and then compares it (S_LK_CMP).
// An insert walks down from the last entry, moving each larger start up one place, then writes the new entry.
// Rejected inserts and lookups on an empty table go straight to the result.
// One item at a time: in_stall holds off new input until the result has been taken; the table read is registered.
// Reset clears the entry count and the handshake state; table contents are not cleared.

module sorted_range_table_lookup_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] range_start,
  input  logic [31:0] range_end,
  input  logic [15:0] symbol_id,
  input  logic [31:0] lookup_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        found,
  output logic        is_entry,
  output logic [15:0] match_id
);

  srtl_pkg::mem_req_t mem_req;
  srtl_pkg::entry_t   rd_entry;
  srtl_pkg::result_t  res;
  logic               res_valid;
  logic               res_ready;

  srtl_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .range_start (range_start),
    .range_end   (range_end),
    .symbol_id   (symbol_id),
    .lookup_addr (lookup_addr),
    .mem_req     (mem_req),
    .rd_entry    (rd_entry),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  srtl_ram #(
    .WIDTH ($bits(srtl_pkg::entry_t)),
    .DEPTH (srtl_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_entry)
  );

  // Output register: take a new result when empty or being drained.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      status   <= res.status;
      found    <= res.found;
      is_entry <= res.is_entry;
      match_id <= res.match_id;
    end
  end

endmodule

FILE: sv/srtl_ram.sv
`timescale 1ns / 1ps

module srtl_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/srtl_engine.sv
`timescale 1ns / 1ps

module srtl_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [31:0]         range_start,
  input  logic [31:0]         range_end,
  input  logic [15:0]         symbol_id,
  input  logic [31:0]         lookup_addr,
  output srtl_pkg::mem_req_t  mem_req,
  input  srtl_pkg::entry_t    rd_entry,
  output logic                res_valid,
  output srtl_pkg::result_t   res,
  input  logic                res_ready
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LK_RD   = 3'd1;
  localparam logic [2:0] S_LK_CMP  = 3'd2;
  localparam logic [2:0] S_INS_CMP = 3'd3;
  localparam logic [2:0] S_INS_PUT = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  localparam logic [srtl_pkg::CNT_W-1:0] FULL_CNT =
    srtl_pkg::CNT_W'(srtl_pkg::TABLE_DEPTH);

  logic [2:0]                   state, state_next;
  logic [srtl_pkg::CNT_W-1:0]   count, count_next;
  srtl_pkg::entry_t             key, key_next;
  logic [31:0]                  addr, addr_next;
  logic [srtl_pkg::CNT_W-1:0]   lo, lo_next;
  logic [srtl_pkg::CNT_W-1:0]   hi_p1, hi_p1_next;
  logic [srtl_pkg::IDX_W-1:0]   mid, mid_next;
  logic [srtl_pkg::IDX_W-1:0]   ptr, ptr_next;
  srtl_pkg::result_t            res_q, res_next;

  logic                         accept;
  logic [srtl_pkg::CNT_W-1:0]   span;
  logic                         go_left, go_right;
  logic [srtl_pkg::CNT_W-1:0]   mid_ext;

  assign accept    = in_valid && (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

  // Half of the open interval; lo < hi_p1 holds whenever this is used.
  assign span    = (hi_p1 - lo - srtl_pkg::CNT_W'(1)) >> 1;
  assign mid_ext = srtl_pkg::CNT_W'(mid);

  // A zero-size entry matches its start address only.
  assign go_left  = addr < rd_entry.base;
  assign go_right = !go_left && ((rd_entry.base == rd_entry.limit) ?
                                 (addr > rd_entry.limit) : (addr >= rd_entry.limit));

  always_comb begin
    state_next = state;
    count_next = count;
    key_next   = key;
    addr_next  = addr;
    lo_next    = lo;
    hi_p1_next = hi_p1;
    mid_next   = mid;
    ptr_next   = ptr;
    res_next   = res_q;
    mem_req    = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_next  = '0;
          key_next  = '{base: range_start, limit: range_end, sym: symbol_id};
          addr_next = lookup_addr;
          lo_next   = '0;
          hi_p1_next = count;
          if (func == srtl_pkg::FUNC_INSERT) begin
            if (range_end < range_start) begin
              res_next.status = srtl_pkg::ST_BADRANGE;
              state_next      = S_DONE;
            end else if (count == FULL_CNT) begin
              res_next.status = srtl_pkg::ST_FULL;
              state_next      = S_DONE;
            end else if (count == '0) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = '0;
              mem_req.wr_data = '{base: range_start, limit: range_end, sym: symbol_id};
              count_next      = count + srtl_pkg::CNT_W'(1);
              res_next.status = srtl_pkg::ST_OK;
              state_next      = S_DONE;
            end else begin
              // Walk down from the last entry, moving larger starts up one place.
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = srtl_pkg::IDX_W'(count - srtl_pkg::CNT_W'(1));
              ptr_next        = srtl_pkg::IDX_W'(count - srtl_pkg::CNT_W'(1));
              state_next      = S_INS_CMP;
            end
          end else begin
            if (count == '0) begin
              res_next.status = srtl_pkg::ST_MISS;
              state_next      = S_DONE;
            end else begin
              state_next = S_LK_RD;
            end
          end
        end
      end

      S_LK_RD: begin
        mid_next        = srtl_pkg::IDX_W'(lo + span);
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = srtl_pkg::IDX_W'(lo + span);
        state_next      = S_LK_CMP;
      end

      S_LK_CMP: begin
        if (go_left) begin
          hi_p1_next = mid_ext;
          state_next = (lo < mid_ext) ? S_LK_RD : S_DONE;
          res_next.status = srtl_pkg::ST_MISS;
        end else if (go_right) begin
          lo_next    = mid_ext + srtl_pkg::CNT_W'(1);
          state_next = ((mid_ext + srtl_pkg::CNT_W'(1)) < hi_p1) ? S_LK_RD : S_DONE;
          res_next.status = srtl_pkg::ST_MISS;
        end else begin
          res_next.status   = srtl_pkg::ST_OK;
          res_next.found    = 1'b1;
          res_next.is_entry = (addr == rd_entry.base);
          res_next.match_id = rd_entry.sym;
          state_next        = S_DONE;
        end
      end

      S_INS_CMP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ptr + srtl_pkg::IDX_W'(1);
        if (rd_entry.base > key.base) begin
          mem_req.wr_data = rd_entry;
          if (ptr == '0) begin
            state_next = S_INS_PUT;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ptr - srtl_pkg::IDX_W'(1);
            ptr_next        = ptr - srtl_pkg::IDX_W'(1);
          end
        end else begin
          mem_req.wr_data = key;
          count_next      = count + srtl_pkg::CNT_W'(1);
          res_next.status = srtl_pkg::ST_OK;
          state_next      = S_DONE;
        end
      end

      S_INS_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = '0;
        mem_req.wr_data = key;
        count_next      = count + srtl_pkg::CNT_W'(1);
        res_next.status = srtl_pkg::ST_OK;
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    addr  <= addr_next;
    lo    <= lo_next;
    hi_p1 <= hi_p1_next;
    mid   <= mid_next;
    ptr   <= ptr_next;
    res_q <= res_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above table depth");

  a_lookup_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_LK_RD || state == S_LK_CMP) |-> !mem_req.wr_en)
    else $error("table written during a lookup");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LK_CMP) |-> (mid_ext >= lo && mid_ext < hi_p1 && hi_p1 <= count))
    else $error("search probe outside the live interval");

  a_no_addr_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
    else $error("read and write hit the same entry");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + srtl_pkg::CNT_W'(1) && state == S_DONE))
    else $error("entry count moved other than by one insert");

endmodule
